// ===== sv/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and codes shared by the shortest-job-first dispatcher files.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int TIME_W = 23;
  localparam logic [TIME_W-1:0] TIME_MAX = 23'h7FFFFF;

  localparam logic OP_SUBMIT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [2:0] ST_DISPATCHED = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_ACCEPTED   = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_ORDER      = 3'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arr;
    logic [15:0] bst;
  } job_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] process_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [15:0]       run_id;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } rsp_t;

endpackage

// ===== sv/sjf_if.sv =====
// ----------------------------------------------------------------------------
// sjf_req_if / sjf_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sjf_req_if;
  logic          valid;
  logic          ready;
  sjf_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sjf_rsp_if;
  logic          valid;
  logic          ready;
  sjf_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sjf_ram.sv =====
// ----------------------------------------------------------------------------
// sjf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sjf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/shortest_job_first_dispatcher.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_dispatcher
// Non-preemptive SJF dispatcher: arrival FIFO feeding a burst-keyed min-heap.
// ----------------------------------------------------------------------------
// One request at a time. A dispatch walks the heap through one single-port
// RAM, one read or write per cycle: the admission pass moves each due FIFO
// head into the heap and climbs it level by level until a compare stops it,
// ends on an empty FIFO or a head not yet due, and may make an idle time
// jump to the FIFO head's arrival when the heap is empty; the pop takes the
// top, reads the last leaf and sinks it level by level until a compare
// stops it. The result sits in an output register; the next request is
// taken once it has been handed off.
module shortest_job_first_dispatcher #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  sjf_req_if.sink   req,
  sjf_rsp_if.source rsp
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int TW = sjf_pkg::TIME_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ADM    = 5'd1;  // check fifo head
  localparam logic [4:0] S_FRD    = 5'd2;  // fifo read wait
  localparam logic [4:0] S_UPRD   = 5'd4;  // read parent
  localparam logic [4:0] S_UPW    = 5'd5;  // parent data in, compare
  localparam logic [4:0] S_UPW2   = 5'd6;  // write parent to child slot
  localparam logic [4:0] S_AFTER  = 5'd7;  // after admission pass
  localparam logic [4:0] S_TOPRD  = 5'd8;
  localparam logic [4:0] S_TOPW   = 5'd9;
  localparam logic [4:0] S_LASTRD = 5'd10;
  localparam logic [4:0] S_LASTW  = 5'd11;
  localparam logic [4:0] S_LRD    = 5'd12;
  localparam logic [4:0] S_LW     = 5'd13;
  localparam logic [4:0] S_RW     = 5'd14;
  localparam logic [4:0] S_DNW    = 5'd15; // write child into hole
  localparam logic [4:0] S_FINAL  = 5'd16; // write sift item at hole
  localparam logic [4:0] S_DONE   = 5'd17;
  localparam logic [4:0] S_PEEK   = 5'd18; // read fifo head for time jump
  localparam logic [4:0] S_PEEKW  = 5'd19;
  localparam logic [4:0] S_UPFIN  = 5'd20; // write pushed item at hole

  logic [4:0] state;
  logic [AW-1:0] fifo_head;
  logic [CW-1:0] fifo_count, heap_count;
  logic [TW-1:0] now_time;
  logic [15:0] last_arrival;
  logic jumped;

  sjf_pkg::job_t item, top, cand;
  logic [AW-1:0] hole, lidx;
  logic [AW:0]   child_l;

  logic          f_we, h_we;
  logic [AW-1:0] f_addr, h_addr;
  sjf_pkg::job_t f_wdata, h_wdata, f_rdata, h_rdata;

  sjf_ram #(.WIDTH($bits(sjf_pkg::job_t)), .DEPTH(DEPTH)) u_fifo (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));
  sjf_ram #(.WIDTH($bits(sjf_pkg::job_t)), .DEPTH(DEPTH)) u_heap (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail, head_inc;
  logic [CW:0]   total;
  logic [AW-1:0] parent;
  logic [2:0]    sub_status;
  // fifo pointers wrap at DEPTH, which need not be a power of two
  assign tail_sum = {1'b0, fifo_head} + fifo_count;
  assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : tail_sum[AW-1:0];
  assign head_inc = (fifo_head == AW'(DEPTH - 1)) ? '0 : fifo_head + 1'b1;
  assign total    = {1'b0, fifo_count} + {1'b0, heap_count};
  assign parent   = (hole - 1'b1) >> 1;

  // order check ranks ahead of the capacity check
  assign sub_status = (req.data.arrival < last_arrival) ? sjf_pkg::ST_ORDER :
                      (total >= (CW+1)'(DEPTH))        ? sjf_pkg::ST_FULL  :
                                                         sjf_pkg::ST_ACCEPTED;

  // completion math, one add/compare each
  logic [TW:0]   sum;
  logic [TW-1:0] cmpl, tat;
  assign sum  = {1'b0, now_time} + {8'd0, top.bst};
  assign cmpl = (sum > {1'b0, sjf_pkg::TIME_MAX}) ? sjf_pkg::TIME_MAX : sum[TW-1:0];
  assign tat  = (cmpl >= {7'd0, top.arr}) ? cmpl - {7'd0, top.arr} : '0;

  assign req.ready = (state == S_IDLE) && !rsp.valid;

  always_comb begin
    f_we = 1'b0; f_addr = fifo_head;
    f_wdata = {req.data.process_id, req.data.arrival, req.data.burst};
    h_we = 1'b0; h_addr = hole; h_wdata = item;
    case (state)
      S_IDLE: if (req.valid && req.ready && req.data.operation == sjf_pkg::OP_SUBMIT
                  && sub_status == sjf_pkg::ST_ACCEPTED) begin
        f_we = 1'b1; f_addr = tail;
      end
      S_UPRD:  h_addr = parent;
      S_UPW2:  begin h_we = 1'b1; h_addr = hole; h_wdata = cand; end
      S_UPFIN: begin h_we = 1'b1; h_addr = hole; h_wdata = item; end
      S_TOPRD: h_addr = '0;
      S_LASTRD: h_addr = heap_count[AW-1:0];
      S_LRD:   h_addr = child_l[AW-1:0];
      S_LW:    h_addr = child_l[AW-1:0] + 1'b1;
      S_DNW:   begin h_we = 1'b1; h_addr = hole; h_wdata = cand; end
      S_FINAL: begin h_we = 1'b1; h_addr = hole; h_wdata = item; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fifo_head <= '0; fifo_count <= '0; heap_count <= '0;
      now_time <= '0; last_arrival <= '0; rsp.valid <= 1'b0; jumped <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: if (req.valid && req.ready) begin
          jumped <= 1'b0;
          if (req.data.operation == sjf_pkg::OP_SUBMIT) begin
            rsp.valid <= 1'b1;
            rsp.data <= {sub_status, {($bits(sjf_pkg::rsp_t) - 3){1'b0}}};
            if (sub_status == sjf_pkg::ST_ACCEPTED) begin
              fifo_count <= fifo_count + 1'b1;
              last_arrival <= req.data.arrival;
            end
          end else begin
            rsp.data <= '0;
            state <= S_ADM;
          end
        end
        S_ADM: state <= (fifo_count != '0) ? S_FRD : S_AFTER;
        S_FRD: begin
          // f_rdata is head entry now
          if ({7'd0, f_rdata.arr} <= now_time) begin
            item <= f_rdata;
            hole <= heap_count[AW-1:0];
            heap_count <= heap_count + 1'b1;
            fifo_head <= head_inc;
            fifo_count <= fifo_count - 1'b1;
            state <= (heap_count == '0) ? S_UPFIN : S_UPRD;
          end else state <= S_AFTER;
        end
        S_UPRD: state <= S_UPW;
        S_UPW: begin
          if (item.bst < h_rdata.bst) begin
            cand <= h_rdata; state <= S_UPW2;
          end else state <= S_UPFIN;
        end
        S_UPW2: begin
          hole <= parent;
          state <= (parent == '0) ? S_UPFIN : S_UPRD;
        end
        S_UPFIN: state <= S_ADM;
        S_AFTER: begin
          if (heap_count != '0) state <= S_TOPRD;
          else if (fifo_count == '0 || jumped) begin
            rsp.data.status <= sjf_pkg::ST_EMPTY; rsp.valid <= 1'b1; state <= S_IDLE;
          end else state <= S_PEEK;
        end
        S_PEEK: state <= S_PEEKW;
        S_PEEKW: begin
          if ({7'd0, f_rdata.arr} > now_time) now_time <= {7'd0, f_rdata.arr};
          jumped <= 1'b1;
          state <= S_ADM;
        end
        S_TOPRD: state <= S_TOPW;
        S_TOPW: begin
          top <= h_rdata;
          heap_count <= heap_count - 1'b1;
          state <= S_LASTRD;
        end
        S_LASTRD: state <= S_LASTW;
        S_LASTW: begin
          item <= h_rdata; hole <= '0; child_l <= (AW+1)'(1);
          state <= (heap_count > CW'(1)) ? S_LRD : S_FINAL;
        end
        S_LRD: state <= S_LW;
        S_LW: begin
          cand <= h_rdata;
          lidx <= child_l[AW-1:0];
          state <= S_RW;
        end
        S_RW: begin
          // h_rdata is right child when it exists
          logic use_r;
          sjf_pkg::job_t c;
          logic [AW-1:0] ci;
          use_r = ({1'b0, child_l} + 1'b1 < {1'b0, heap_count}) && (h_rdata.bst < cand.bst);
          c  = use_r ? h_rdata : cand;
          ci = use_r ? lidx + 1'b1 : lidx;
          if (c.bst < item.bst) begin
            cand <= c; lidx <= ci; state <= S_DNW;
          end else state <= S_FINAL;
        end
        S_DNW: begin
          hole <= lidx;
          child_l <= {lidx, 1'b0} + 1'b1;
          if ({lidx, 1'b0} + (AW+1)'(1) < heap_count[AW:0] && {1'b0, lidx} < (AW+1)'(DEPTH/2))
            state <= S_LRD;
          else state <= S_FINAL;
        end
        S_FINAL: state <= S_DONE;
        S_DONE: begin
          now_time <= cmpl;
          rsp.data.status <= sjf_pkg::ST_DISPATCHED;
          rsp.data.run_id <= top.id;
          rsp.data.completion <= cmpl;
          rsp.data.turnaround <= tat;
          rsp.data.waiting <= (tat >= {7'd0, top.bst}) ? tat - {7'd0, top.bst} : '0;
          rsp.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/sjf_checker.sv =====
// ----------------------------------------------------------------------------
// sjf_checker
// Port-level checks on the dispatcher.
// ----------------------------------------------------------------------------
module sjf_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sjf_pkg::rsp_t rsp_data
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped");
  a_submit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != sjf_pkg::ST_DISPATCHED |-> rsp_data.run_id == '0
      && rsp_data.completion == '0) else $error("fields not zero");
  a_wait: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.waiting <= rsp_data.turnaround) else $error("waiting too big");
endmodule

bind shortest_job_first_dispatcher sjf_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

// ===== verif/shortest_job_first_dispatcher_test.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_dispatcher_test
// Drives submits and dispatches into the SJF dispatcher under random idling and
// checks every result against a behavioral model of the FIFO and burst heap.
// ----------------------------------------------------------------------------
class sjf_scoreboard;
  localparam int DEPTH = 64;
  sjf_pkg::job_t fifo_q[$];
  sjf_pkg::job_t heap[DEPTH];
  int unsigned heap_n;
  logic [22:0] now_t;
  logic [15:0] last_arr;
  sjf_pkg::rsp_t expected_q[$];
  int errors;
  int n_dispatched;
  int n_rejected;

  function new();
    heap_n = 0;
    now_t = '0;
    last_arr = '0;
    errors = 0;
    n_dispatched = 0;
    n_rejected = 0;
  endfunction

  function int unsigned occupancy();
    return fifo_q.size() + heap_n;
  endfunction

  function void heap_insert(sjf_pkg::job_t j);
    int unsigned i, p;
    sjf_pkg::job_t t;
    i = heap_n;
    heap[i] = j;
    heap_n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap[i].bst < heap[p].bst) begin
        t = heap[i]; heap[i] = heap[p]; heap[p] = t;
        i = p;
      end else break;
    end
  endfunction

  function sjf_pkg::job_t heap_take();
    sjf_pkg::job_t top, t;
    int unsigned i, l, r, c;
    top = heap[0];
    i = 0;
    heap_n--;
    heap[0] = heap[heap_n];
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      if (l >= heap_n) break;
      c = l;
      if (r < heap_n && heap[r].bst < heap[l].bst) c = r;
      if (heap[c].bst < heap[i].bst) begin
        t = heap[i]; heap[i] = heap[c]; heap[c] = t;
        i = c;
      end else break;
    end
    return top;
  endfunction

  function void admit_arrived();
    while (fifo_q.size() > 0 && heap_n < DEPTH && fifo_q[0].arr <= now_t)
      heap_insert(fifo_q.pop_front());
  endfunction

  function void note_request(sjf_pkg::req_t rq);
    sjf_pkg::rsp_t e;
    sjf_pkg::job_t j;
    logic [23:0] sum;
    logic [22:0] tat;
    e = '0;
    if (rq.operation == sjf_pkg::OP_SUBMIT) begin
      if (rq.arrival < last_arr) begin
        e.status = sjf_pkg::ST_ORDER;
        n_rejected++;
      end else if (occupancy() >= DEPTH) begin
        e.status = sjf_pkg::ST_FULL;
        n_rejected++;
      end else begin
        j.id = rq.process_id;
        j.arr = rq.arrival;
        j.bst = rq.burst;
        fifo_q.insert(fifo_q.size(), j);
        last_arr = rq.arrival;
        e.status = sjf_pkg::ST_ACCEPTED;
      end
    end else begin
      admit_arrived();
      if (heap_n == 0 && fifo_q.size() == 0) begin
        e.status = sjf_pkg::ST_EMPTY;
      end else begin
        if (heap_n == 0) begin
          if (fifo_q[0].arr > now_t) now_t = 23'(fifo_q[0].arr);
          admit_arrived();
        end
        j = heap_take();
        sum = now_t + j.bst;
        now_t = (sum > sjf_pkg::TIME_MAX) ? sjf_pkg::TIME_MAX : sum[22:0];
        tat = (now_t >= j.arr) ? now_t - j.arr : '0;
        e.status = sjf_pkg::ST_DISPATCHED;
        e.run_id = j.id;
        e.completion = now_t;
        e.turnaround = tat;
        e.waiting = (tat >= j.bst) ? tat - j.bst : '0;
        n_dispatched++;
      end
    end
    expected_q.insert(expected_q.size(), e);
  endfunction

  function void check_result(sjf_pkg::rsp_t a);
    sjf_pkg::rsp_t e;
    if (expected_q.size() == 0) begin
      $error("result with nothing outstanding: %p", a);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (a.status !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, a.status); errors++;
    end
    if (a.run_id !== e.run_id) begin
      $error("run_id: expected %0d actual %0d", e.run_id, a.run_id); errors++;
    end
    if (a.completion !== e.completion) begin
      $error("completion: expected %0d actual %0d", e.completion, a.completion); errors++;
    end
    if (a.turnaround !== e.turnaround) begin
      $error("turnaround: expected %0d actual %0d", e.turnaround, a.turnaround); errors++;
    end
    if (a.waiting !== e.waiting) begin
      $error("waiting: expected %0d actual %0d", e.waiting, a.waiting); errors++;
    end
  endfunction
endclass

module shortest_job_first_dispatcher_test;

  localparam int N_RANDOM = 650;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycle_cnt = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  logic [15:0] arr_cursor = '0;

  sjf_req_if req_ch();
  sjf_rsp_if rsp_ch();
  sjf_scoreboard sched_model = new();

  shortest_job_first_dispatcher #(.DEPTH(64)) u_top (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  // accepted requests and results go to the scoreboard
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) sched_model.note_request(req_ch.data);
    if (!rst && rsp_ch.valid && rsp_ch.ready) sched_model.check_result(rsp_ch.data);
  end

  // receiver: random stalls, periodic all-ready spans, long hold-off when asked
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (hold_off) rsp_ch.ready <= 1'b0;
    else if (cycle_cnt[9:8] == 2'b11) rsp_ch.ready <= 1'b1;
    else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_request(input sjf_pkg::req_t rq);
    req_ch.valid <= 1'b1;
    req_ch.data <= rq;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic idle_gap(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic sjf_pkg::req_t submit_req(input logic [15:0] id, input logic [15:0] a,
                                               input logic [15:0] b);
    sjf_pkg::req_t rq;
    rq.operation = sjf_pkg::OP_SUBMIT;
    rq.process_id = id;
    rq.arrival = a;
    rq.burst = b;
    return rq;
  endfunction

  function automatic sjf_pkg::req_t dispatch_req();
    sjf_pkg::req_t rq;
    rq = sjf_pkg::req_t'({$urandom, $urandom});
    rq.operation = sjf_pkg::OP_DISPATCH;
    return rq;
  endfunction

  // mostly in-order submits with small steps, some late ones, some dispatches
  function automatic sjf_pkg::req_t random_req();
    logic [15:0] a;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return dispatch_req();
    if (pick < 45) begin
      a = (arr_cursor == 0) ? 16'($urandom) : 16'($urandom_range(0, arr_cursor - 1));
    end else begin
      if ($urandom_range(0, 30) == 0) arr_cursor = '0;  // noise: jumps after wrap
      a = arr_cursor + 16'($urandom_range(0, 40));
      if (a < arr_cursor) a = 16'hFFFF;
      arr_cursor = a;
    end
    return submit_req(16'($urandom),
                      a,
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)));
  endfunction

  initial begin
    int sent;
    int burst_len;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty dispatch, ordering, extremes, ties, idle time jump
    send_request(dispatch_req());
    send_request(submit_req(16'h0000, 16'd5, 16'd0));
    send_request(submit_req(16'hFFFF, 16'd5, 16'd7));
    send_request(submit_req(16'h1234, 16'd3, 16'd1));
    send_request(submit_req(16'h00AA, 16'd9, 16'd7));
    send_request(submit_req(16'h00AB, 16'd9, 16'd7));
    send_request(dispatch_req());
    send_request(dispatch_req());
    send_request(dispatch_req());
    send_request(dispatch_req());
    send_request(dispatch_req());
    send_request(submit_req(16'h5555, 16'd1000, 16'hFFFF));
    send_request(dispatch_req());
    send_request(submit_req(16'hAAAA, 16'hFFFF, 16'hFFFF));
    send_request(submit_req(16'h0F0F, 16'hFFFF, 16'h8000));
    // burn time toward saturation
    repeat (130) begin
      send_request(submit_req(16'($urandom), 16'hFFFF, 16'hFFFF));
      send_request(dispatch_req());
    end
    send_request(dispatch_req());
    send_request(dispatch_req());
    send_request(dispatch_req());

    // pressure: hold results back, then fill the block until it rejects submits
    hold_off <= 1'b1;
    fork
      begin repeat (400) @(posedge clk); hold_off <= 1'b0; end
      repeat (70) send_request(submit_req(16'($urandom), 16'hFFFF, 16'($urandom)));
    join
    repeat (70) send_request(dispatch_req());
    arr_cursor = 16'hFFFF;
    repeat (3) send_request(submit_req(16'h0001, 16'h0000, 16'h0001));

    // random bursts; time is saturated, so every arrival is already due
    sent = 0;
    while (sent < N_RANDOM) begin
      burst_len = $urandom_range(1, 20);
      repeat (burst_len) begin
        send_request(random_req());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
    end
    req_ch.valid <= 1'b0;

    while (sched_model.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("dispatched %0d jobs, rejected %0d submits", sched_model.n_dispatched,
             sched_model.n_rejected);
    if (sched_model.errors == 0 && sched_model.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
